FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers for the core rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define QRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked on every rising clk edge outside reset
`define QRS_ASSERT_IMP(lbl, pre, post, msg) \
	`QRS_ASSERT(lbl, (pre) |-> (post), msg)

`endif

FILE: rtl/core/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// widths, status codes and stage records for the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int DW        = 32;
	localparam int FB        = 16;
	localparam int DISC_W    = 2 * DW + 2;
	localparam int ROOT_W    = DW + 1;
	localparam int DEN_W     = DW + 1;
	localparam int NUM_W     = DW + 4;
	localparam int MAG_W     = DW + 2;
	localparam int REM_W     = DW + 2;
	localparam int SQ_W      = DW + 4;
	localparam int SQ_STEPS  = ROOT_W;
	localparam int DIV_STEPS = DW;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef struct packed {
		logic                 zero;
		logic                 a_neg;
		logic                 dneg;
		logic signed [DW-1:0] b;
		logic [DEN_W-1:0]     den;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DW-1:0]    low;
		logic [DW-1:0]    q;
		logic             ovf;
		logic             neg;
	} lane_t;

endpackage

FILE: rtl/core/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// roots of a*x^2+b*x+c on signed q16.16 coefficients, fully pipelined
// ----------------------------------------------------------------------------
// Accepts one coefficient set per cycle while the pipeline advances and
// returns one root pair per set, in order. Discriminant stages form the
// discriminant, square-root stages take its root one bit per stage, a prep
// stage forms the numerators, divider stages divide by 2a one quotient bit
// per stage, and the output register takes the saturated roots. The whole
// pipeline advances whenever the output register is empty or being taken, so
// a held result stalls every stage without losing or repeating a transaction.
module quadratic_root_solver (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [95:0]   s_tdata,  // coef_a, coef_b, coef_c
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata,  // first_real, first_imag, second_real, second_imag
	output logic [2:0]    m_tuser   // roots_complex, status
);

	`include "assert_macros.svh"

	localparam int DW = qrs_pkg::DW;
	localparam int CW = qrs_pkg::DEN_W + DW;
	localparam int SW = qrs_pkg::MAG_W + qrs_pkg::FB;

	function automatic qrs_pkg::lane_t prep(input logic [qrs_pkg::NUM_W-1:0] n,
			input logic a_neg, input logic [qrs_pkg::DEN_W-1:0] den);
		qrs_pkg::lane_t            l;
		logic [qrs_pkg::NUM_W-1:0] m;
		logic [SW-1:0]             nsc;
		m   = n[qrs_pkg::NUM_W-1] ? (~n + 1'b1) : n;
		nsc = SW'(m[qrs_pkg::MAG_W-1:0]) << qrs_pkg::FB;
		l.rem = qrs_pkg::REM_W'(nsc >> DW);
		l.low = nsc[DW-1:0];
		l.q   = '0;
		l.ovf = CW'(nsc) >= (CW'(den) << DW);
		l.neg = n[qrs_pkg::NUM_W-1] ^ a_neg;
		return l;
	endfunction

	function automatic logic [DW:0] clamp(input logic [DW-1:0] q, input logic ovf,
			input logic neg);
		logic [DW-1:0] lim, v;
		logic          sat;
		lim = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		sat = ovf || (q > lim);
		v   = sat ? lim : q;
		return {sat, neg ? (~v + 1'b1) : v};
	endfunction

	logic                        en;
	logic                        dsc_vld, sq_vld, dv_vld;
	logic [qrs_pkg::DISC_W-1:0]  dmag;
	qrs_pkg::side_t              dsc_side, sq_side, dv_side;
	logic [qrs_pkg::ROOT_W-1:0]  root;
	logic [qrs_pkg::NUM_W-1:0]   bb, rt, n0, n1;
	logic                        vld_s3;
	qrs_pkg::lane_t              l0_s3, l1_s3, dv_l0, dv_l1;
	qrs_pkg::side_t              side_s3;
	logic [DW:0]                 c0, c1, c2;
	logic                        out_vld_q;
	logic [DW-1:0]               r1_q, i1_q, r2_q, i2_q;
	logic                        cplx_q;
	qrs_pkg::status_t            status_q, status_n;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	qrs_disc u_disc (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.a       (s_tdata[31:0]),
		.b       (s_tdata[63:32]),
		.c       (s_tdata[95:64]),
		.out_vld (dsc_vld),
		.dmag    (dmag),
		.side    (dsc_side)
	);

	qrs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (dsc_vld),
		.dmag     (dmag),
		.in_side  (dsc_side),
		.out_vld  (sq_vld),
		.root     (root),
		.out_side (sq_side)
	);

	assign bb = {{(qrs_pkg::NUM_W-DW){sq_side.b[DW-1]}}, sq_side.b};
	assign rt = qrs_pkg::NUM_W'(root);
	assign n0 = sq_side.dneg ? (~bb + 1'b1) : (rt - bb);
	assign n1 = sq_side.dneg ? rt : ((~bb + 1'b1) - rt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l0_s3   <= prep(n0, sq_side.a_neg, sq_side.den);
			l1_s3   <= prep(n1, sq_side.a_neg, sq_side.den);
			side_s3 <= sq_side;
		end
	end

	qrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_l0    (l0_s3),
		.in_l1    (l1_s3),
		.in_side  (side_s3),
		.out_vld  (dv_vld),
		.out_l0   (dv_l0),
		.out_l1   (dv_l1),
		.out_side (dv_side)
	);

	assign c0 = clamp(dv_l0.q, dv_l0.ovf, dv_l0.neg);
	assign c1 = clamp(dv_l1.q, dv_l1.ovf, dv_l1.neg);
	assign c2 = clamp(dv_l1.q, dv_l1.ovf, !dv_l1.neg);

	always_comb begin
		if (dv_side.zero) begin
			status_n = qrs_pkg::ST_ZERO;
		end else if (c0[DW] || c1[DW] || (dv_side.dneg && c2[DW])) begin
			status_n = qrs_pkg::ST_SAT;
		end else begin
			status_n = qrs_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= status_n;
			if (dv_side.zero) begin
				r1_q   <= '0;
				i1_q   <= '0;
				r2_q   <= '0;
				i2_q   <= '0;
				cplx_q <= 1'b0;
			end else if (dv_side.dneg) begin
				r1_q   <= c0[DW-1:0];
				i1_q   <= c1[DW-1:0];
				r2_q   <= c0[DW-1:0];
				i2_q   <= c2[DW-1:0];
				cplx_q <= 1'b1;
			end else begin
				r1_q   <= c0[DW-1:0];
				i1_q   <= '0;
				r2_q   <= c1[DW-1:0];
				i2_q   <= '0;
				cplx_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {i2_q, r2_q, i1_q, r1_q};
	assign m_tuser  = {status_q, cplx_q};

	`QRS_ASSERT_IMP(a_zero_clears, m_tvalid && (status_q == qrs_pkg::ST_ZERO), (m_tdata == '0) && !cplx_q, "zero leading coefficient must clear roots")
	`QRS_ASSERT_IMP(a_conj_pair, m_tvalid && cplx_q && (status_q == qrs_pkg::ST_OK), (r1_q == r2_q) && (i1_q == (~i2_q + 1'b1)), "complex roots must form a conjugate pair")
	`QRS_ASSERT_IMP(a_real_imag, m_tvalid && !cplx_q, (i1_q == '0) && (i2_q == '0), "real roots must have zero imaginary parts")
	`QRS_ASSERT_IMP(a_stall_hold, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "pending result changed")

endmodule

FILE: rtl/core/qrs_disc.sv
// ----------------------------------------------------------------------------
// qrs_disc
// two-stage discriminant: magnitudes and products, then signed combine
// ----------------------------------------------------------------------------
module qrs_disc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic signed [qrs_pkg::DW-1:0] a,
	input  logic signed [qrs_pkg::DW-1:0] b,
	input  logic signed [qrs_pkg::DW-1:0] c,
	output logic                         out_vld,
	output logic [qrs_pkg::DISC_W-1:0]   dmag,
	output qrs_pkg::side_t               side
);

	logic [qrs_pkg::DW-1:0]     ma, mb, mc;
	logic                       vld_s1;
	logic [qrs_pkg::DW-1:0]     ma_s1;
	logic [2*qrs_pkg::DW-1:0]   b2_s1, ac_s1;
	logic                       a_neg_s1, opp_s1, zero_s1;
	logic signed [qrs_pkg::DW-1:0] b_s1;
	logic [qrs_pkg::DISC_W-1:0] b2e, ac4, dmag_n;
	logic                       dneg_n;
	logic                       vld_s2;
	logic [qrs_pkg::DISC_W-1:0] dmag_s2;
	qrs_pkg::side_t             side_s2;

	assign ma = a[qrs_pkg::DW-1] ? (~a + 1'b1) : a;
	assign mb = b[qrs_pkg::DW-1] ? (~b + 1'b1) : b;
	assign mc = c[qrs_pkg::DW-1] ? (~c + 1'b1) : c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1    <= ma;
			b2_s1    <= mb * mb;
			ac_s1    <= ma * mc;
			a_neg_s1 <= a[qrs_pkg::DW-1];
			opp_s1   <= (c != '0) && (a[qrs_pkg::DW-1] != c[qrs_pkg::DW-1]);
			zero_s1  <= (a == '0);
			b_s1     <= b;
		end
	end

	assign b2e = qrs_pkg::DISC_W'(b2_s1);
	assign ac4 = {ac_s1, 2'b00};

	always_comb begin
		dneg_n = 1'b0;
		if (opp_s1) begin
			dmag_n = b2e + ac4;
		end else if (b2e >= ac4) begin
			dmag_n = b2e - ac4;
		end else begin
			dmag_n = ac4 - b2e;
			dneg_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s2       <= dmag_n;
			side_s2.zero  <= zero_s1;
			side_s2.a_neg <= a_neg_s1;
			side_s2.dneg  <= dneg_n;
			side_s2.b     <= b_s1;
			side_s2.den   <= {ma_s1, 1'b0};
		end
	end

	assign out_vld = vld_s2;
	assign dmag    = dmag_s2;
	assign side    = side_s2;

endmodule

FILE: rtl/core/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined digit-by-digit integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module qrs_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic [qrs_pkg::DISC_W-1:0]   dmag,
	input  qrs_pkg::side_t               in_side,
	output logic                         out_vld,
	output logic [qrs_pkg::ROOT_W-1:0]   root,
	output qrs_pkg::side_t               out_side
);

	logic                       vld_s  [qrs_pkg::SQ_STEPS+1];
	logic [qrs_pkg::SQ_W-1:0]   rem_s  [qrs_pkg::SQ_STEPS+1];
	logic [qrs_pkg::ROOT_W-1:0] root_s [qrs_pkg::SQ_STEPS+1];
	logic [qrs_pkg::DISC_W-1:0] n_s    [qrs_pkg::SQ_STEPS+1];
	qrs_pkg::side_t             side_s [qrs_pkg::SQ_STEPS+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign n_s[0]    = dmag;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < qrs_pkg::SQ_STEPS; k++) begin : g_step
		logic [qrs_pkg::SQ_W-1:0] cur, trial;
		logic                     ge;

		always_comb begin
			cur   = {rem_s[k][qrs_pkg::SQ_W-3:0], n_s[k][qrs_pkg::DISC_W-1 -: 2]};
			trial = qrs_pkg::SQ_W'({root_s[k], 2'b01});
			ge    = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? (cur - trial) : cur;
				root_s[k+1] <= {root_s[k][qrs_pkg::ROOT_W-2:0], ge};
				n_s[k+1]    <= n_s[k] << 2;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[qrs_pkg::SQ_STEPS];
	assign root     = root_s[qrs_pkg::SQ_STEPS];
	assign out_side = side_s[qrs_pkg::SQ_STEPS];

endmodule

FILE: rtl/core/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// two-lane pipelined restoring divider sharing one denominator
// ----------------------------------------------------------------------------
module qrs_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  qrs_pkg::lane_t in_l0,
	input  qrs_pkg::lane_t in_l1,
	input  qrs_pkg::side_t in_side,
	output logic           out_vld,
	output qrs_pkg::lane_t out_l0,
	output qrs_pkg::lane_t out_l1,
	output qrs_pkg::side_t out_side
);

	function automatic qrs_pkg::lane_t step(input qrs_pkg::lane_t l,
			input logic [qrs_pkg::DEN_W-1:0] den);
		qrs_pkg::lane_t            r;
		logic [qrs_pkg::REM_W-1:0] cur, d;
		logic                      ge;
		r   = l;
		cur = {l.rem[qrs_pkg::REM_W-2:0], l.low[qrs_pkg::DW-1]};
		d   = qrs_pkg::REM_W'(den);
		ge  = cur >= d;
		r.rem = ge ? (cur - d) : cur;
		r.low = l.low << 1;
		r.q   = {l.q[qrs_pkg::DW-2:0], ge};
		return r;
	endfunction

	logic           vld_s  [qrs_pkg::DIV_STEPS+1];
	qrs_pkg::lane_t l0_s   [qrs_pkg::DIV_STEPS+1];
	qrs_pkg::lane_t l1_s   [qrs_pkg::DIV_STEPS+1];
	qrs_pkg::side_t side_s [qrs_pkg::DIV_STEPS+1];

	assign vld_s[0]  = in_vld;
	assign l0_s[0]   = in_l0;
	assign l1_s[0]   = in_l1;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < qrs_pkg::DIV_STEPS; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				l0_s[k+1]   <= step(l0_s[k], side_s[k].den);
				l1_s[k+1]   <= step(l1_s[k], side_s[k].den);
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[qrs_pkg::DIV_STEPS];
	assign out_l0   = l0_s[qrs_pkg::DIV_STEPS];
	assign out_l1   = l1_s[qrs_pkg::DIV_STEPS];
	assign out_side = side_s[qrs_pkg::DIV_STEPS];

endmodule
